### rtl/core/line_pixel_generator_defines.svh
// Assertion macros shared by the line pixel generator RTL.
// Included by files that carry concurrent checks; no other dependencies.
`ifndef LINE_PIXEL_GENERATOR_DEFINES_SVH
`define LINE_PIXEL_GENERATOR_DEFINES_SVH

// Consequent checked in the same cycle as the antecedent
`define LPG_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Consequent checked in the cycle after the antecedent
`define LPG_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/core/lpg_pkg.sv
// Shared types and constants for the line pixel generator.
// No dependencies; imported by every module of the block.
`default_nettype none

package lpg_pkg;

    localparam int COORD_BITS_DEF = 16;
    localparam int COLOR_BITS     = 32;
    localparam int QUEUE_DEPTH    = 2;

    // Request type carried on the input channel
    typedef enum logic {
        ACT_START = 1'b0,
        ACT_STEP  = 1'b1
    } action_t;

    // Setup record width: three flags, five coordinate-sized words, color
    function automatic int entry_width(input int coord_bits);
        return 5 * coord_bits + 3 + COLOR_BITS;
    endfunction

    // Back-end status seen by the top level checks
    typedef struct packed {
        logic line_active;
        logic emit_last;
    } status_t;

endpackage

`default_nettype wire

### rtl/core/line_pixel_generator.sv
// Top level of the Bresenham line pixel generator.
// Depends on lpg_pkg, lpg_front, lpg_queue, lpg_back and the assertion macro header.
`default_nettype none
`include "line_pixel_generator_defines.svh"

// Accepts one request per clock while s_ready is high: a start request sets
// up a line and yields no pixel, each step request yields the next pixel of
// the active line (nothing when no line is active). Setup is combinational
// into the queue, so a step request that is taken is registered in the
// queue, and the stepper then loads its pixel into the output register, from
// which the m_ channel is driven. Sustained rate is one pixel per clock while
// m_ready is held high, set by the combinational error update in the
// stepper; while the output register is stalled the two-entry queue absorbs
// up to two more requests before s_ready drops.
module line_pixel_generator #(
    parameter int COORD_BITS  = lpg_pkg::COORD_BITS_DEF,
    parameter int QUEUE_DEPTH = lpg_pkg::QUEUE_DEPTH
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          s_valid,
    output logic                               s_ready,
    input  wire logic                          s_action,
    input  wire logic signed [COORD_BITS-1:0]  s_x_start,
    input  wire logic signed [COORD_BITS-1:0]  s_y_start,
    input  wire logic signed [COORD_BITS-1:0]  s_x_end,
    input  wire logic signed [COORD_BITS-1:0]  s_y_end,
    input  wire logic [lpg_pkg::COLOR_BITS-1:0] s_color_in,
    output logic                               m_valid,
    input  wire logic                          m_ready,
    output logic signed [COORD_BITS-1:0]       m_pixel_x,
    output logic signed [COORD_BITS-1:0]       m_pixel_y,
    output logic [lpg_pkg::COLOR_BITS-1:0]     m_color_out,
    output logic                               m_last_pixel
);
    import lpg_pkg::*;

    localparam int ENTRY_W = entry_width(COORD_BITS);

    logic [ENTRY_W-1:0] front_entry;
    logic [ENTRY_W-1:0] q_data;
    logic               q_valid, q_ready;
    status_t            status;

    // Setup of start requests
    lpg_front #(
        .COORD_BITS(COORD_BITS)
    ) u_front (
        .action   (s_action),
        .x_start  (s_x_start),
        .y_start  (s_y_start),
        .x_end    (s_x_end),
        .y_end    (s_y_end),
        .color_in (s_color_in),
        .entry    (front_entry)
    );

    // Decoupling queue
    lpg_queue #(
        .WIDTH(ENTRY_W),
        .DEPTH(QUEUE_DEPTH)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_valid),
        .in_ready  (s_ready),
        .in_data   (front_entry),
        .out_valid (q_valid),
        .out_ready (q_ready),
        .out_data  (q_data)
    );

    // Pixel stepper and output register
    lpg_back #(
        .COORD_BITS(COORD_BITS)
    ) u_back (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .q_valid      (q_valid),
        .q_ready      (q_ready),
        .q_data       (q_data),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_pixel_x    (m_pixel_x),
        .m_pixel_y    (m_pixel_y),
        .m_color_out  (m_color_out),
        .m_last_pixel (m_last_pixel),
        .status       (status)
    );

    // Checks
    `LPG_ASSERT_NEXT(a_last_ends_line, aclk, aresetn, status.emit_last, !status.line_active, "line still active after its last pixel")
    `LPG_ASSERT_NEXT(a_stall_means_queued, aclk, aresetn, s_valid && !s_ready, q_valid, "input stalled but queue drained")
    `LPG_ASSERT_SAME(a_no_pixel_when_idle, aclk, aresetn, !status.line_active, !status.emit_last, "pixel emitted with no active line")

endmodule

`default_nettype wire

### rtl/core/lpg_front.sv
// Front end: decodes a request and does the line setup (axis swap, ordering, deltas).
// Depends on lpg_pkg; feeds lpg_queue.
`default_nettype none

module lpg_front #(
    parameter int COORD_BITS = lpg_pkg::COORD_BITS_DEF
) (
    input  wire logic                                      action,
    input  wire logic signed [COORD_BITS-1:0]              x_start,
    input  wire logic signed [COORD_BITS-1:0]              y_start,
    input  wire logic signed [COORD_BITS-1:0]              x_end,
    input  wire logic signed [COORD_BITS-1:0]              y_end,
    input  wire logic [lpg_pkg::COLOR_BITS-1:0]            color_in,
    output logic [lpg_pkg::entry_width(COORD_BITS)-1:0]    entry
);
    import lpg_pkg::*;

    localparam int CB = COORD_BITS;

    typedef struct packed {
        logic                  is_start;
        logic                  swapped;
        logic                  minor_down;
        logic [CB-1:0]         major_pos;
        logic [CB-1:0]         major_end;
        logic [CB-1:0]         minor_pos;
        logic [CB-1:0]         major_delta;
        logic [CB-1:0]         minor_delta;
        logic [COLOR_BITS-1:0] color;
    } entry_t;

    logic [CB:0]   dx, dy, dx_neg, dy_neg;
    logic [CB-1:0] adx, ady;
    logic          swapped;
    logic [CB:0]   da, db;
    logic [CB-1:0] a0, a1, b0, b1;
    logic          reorder;
    entry_t        ent;

    // Signed deltas with one guard bit, and their magnitudes
    always_comb begin
        dx     = {x_end[CB-1], x_end} - {x_start[CB-1], x_start};
        dy     = {y_end[CB-1], y_end} - {y_start[CB-1], y_start};
        dx_neg = ~dx + (CB+1)'(1);
        dy_neg = ~dy + (CB+1)'(1);
        adx    = dx[CB] ? dx_neg[CB-1:0] : dx[CB-1:0];
        ady    = dy[CB] ? dy_neg[CB-1:0] : dy[CB-1:0];
        swapped = adx < ady;
    end

    // Pick major/minor axis, then order so the major axis counts up
    always_comb begin
        a0      = swapped ? y_start : x_start;
        a1      = swapped ? y_end   : x_end;
        b0      = swapped ? x_start : y_start;
        b1      = swapped ? x_end   : y_end;
        da      = swapped ? dy : dx;
        db      = swapped ? dx : dy;
        reorder = da[CB];

        ent.is_start    = (action_t'(action) == ACT_START);
        ent.swapped     = swapped;
        ent.major_pos   = reorder ? a1 : a0;
        ent.major_end   = reorder ? a0 : a1;
        ent.minor_pos   = reorder ? b1 : b0;
        ent.major_delta = swapped ? ady : adx;
        ent.minor_delta = swapped ? adx : ady;
        // Minor runs downward unless its end lies strictly above its start
        ent.minor_down  = reorder ? !db[CB] : (db[CB] || (db == '0));
        ent.color       = color_in;
    end

    assign entry = ent;

endmodule

`default_nettype wire

### rtl/core/lpg_queue.sv
// Small register FIFO decoupling the setup front end from the pixel stepper.
// Depends on lpg_pkg for default depth.
`default_nettype none

module lpg_queue #(
    parameter int WIDTH = 8,
    parameter int DEPTH = lpg_pkg::QUEUE_DEPTH
) (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             in_valid,
    output logic                  in_ready,
    input  wire logic [WIDTH-1:0] in_data,
    output logic                  out_valid,
    input  wire logic             out_ready,
    output logic [WIDTH-1:0]      out_data
);
    import lpg_pkg::*;

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] store_reg [DEPTH];
    logic [PW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]    count_reg, count_next;
    logic             push, pop;

    assign in_ready  = (count_reg != CW'(DEPTH));
    assign out_valid = (count_reg != '0);
    assign out_data  = store_reg[rd_ptr_reg];
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;

    // Pointer and occupancy update
    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + PW'(1);
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + PW'(1);
        end
        unique case ({push, pop})
            2'b10:   count_next = count_reg + CW'(1);
            2'b01:   count_next = count_reg - CW'(1);
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Payload storage, no reset
    always_ff @(posedge aclk) begin
        if (push) begin
            store_reg[wr_ptr_reg] <= in_data;
        end
    end

endmodule

`default_nettype wire

### rtl/core/lpg_back.sv
// Back end: holds the active line and steps one pixel per request.
// Depends on lpg_pkg; drains lpg_queue and drives the output register.
`default_nettype none

module lpg_back #(
    parameter int COORD_BITS = lpg_pkg::COORD_BITS_DEF
) (
    input  wire logic                                    aclk,
    input  wire logic                                    aresetn,
    input  wire logic                                    q_valid,
    output logic                                         q_ready,
    input  wire logic [lpg_pkg::entry_width(COORD_BITS)-1:0] q_data,
    output logic                                         m_valid,
    input  wire logic                                    m_ready,
    output logic signed [COORD_BITS-1:0]                 m_pixel_x,
    output logic signed [COORD_BITS-1:0]                 m_pixel_y,
    output logic [lpg_pkg::COLOR_BITS-1:0]               m_color_out,
    output logic                                         m_last_pixel,
    output lpg_pkg::status_t                             status
);
    import lpg_pkg::*;

    localparam int CB = COORD_BITS;
    localparam int EB = COORD_BITS + 2;

    typedef struct packed {
        logic                  is_start;
        logic                  swapped;
        logic                  minor_down;
        logic [CB-1:0]         major_pos;
        logic [CB-1:0]         major_end;
        logic [CB-1:0]         minor_pos;
        logic [CB-1:0]         major_delta;
        logic [CB-1:0]         minor_delta;
        logic [COLOR_BITS-1:0] color;
    } entry_t;

    entry_t ent;

    // Line state
    logic                  active_reg, active_next;
    logic                  swapped_reg, swapped_next;
    logic                  minor_down_reg, minor_down_next;
    logic [CB-1:0]         major_pos_reg, major_pos_next;
    logic [CB-1:0]         major_end_reg, major_end_next;
    logic [CB-1:0]         minor_pos_reg, minor_pos_next;
    logic [CB-1:0]         major_delta_reg, major_delta_next;
    logic [CB-1:0]         minor_delta_reg, minor_delta_next;
    logic signed [EB-1:0]  err_reg, err_next;
    logic [COLOR_BITS-1:0] color_reg, color_next;

    // Output register
    logic                  out_valid_reg, out_valid_next;
    logic [CB-1:0]         out_x_reg, out_x_next;
    logic [CB-1:0]         out_y_reg, out_y_next;
    logic [COLOR_BITS-1:0] out_color_reg, out_color_next;
    logic                  out_last_reg, out_last_next;

    logic                  out_free, emit, is_last, minor_move;
    logic signed [EB-1:0]  err_acc;
    logic signed [EB:0]    err_dbl, major_cmp;

    assign ent = entry_t'(q_data);

    // Handshake decisions: a step on an active line needs a free output slot
    always_comb begin
        out_free = !out_valid_reg || m_ready;
        emit     = q_valid && !ent.is_start && active_reg && out_free;
        q_ready  = ent.is_start || !active_reg || out_free;
    end

    // Bresenham error update for the current pixel
    always_comb begin
        is_last    = $signed(major_pos_reg) >= $signed(major_end_reg);
        err_acc    = err_reg + $signed({2'b00, minor_delta_reg});
        err_dbl    = {err_acc, 1'b0};
        major_cmp  = $signed({3'b000, major_delta_reg});
        minor_move = (err_dbl >= major_cmp);
    end

    // Next line state
    always_comb begin
        active_next      = active_reg;
        swapped_next     = swapped_reg;
        minor_down_next  = minor_down_reg;
        major_pos_next   = major_pos_reg;
        major_end_next   = major_end_reg;
        minor_pos_next   = minor_pos_reg;
        major_delta_next = major_delta_reg;
        minor_delta_next = minor_delta_reg;
        err_next         = err_reg;
        color_next       = color_reg;
        if (q_valid && ent.is_start) begin
            active_next      = 1'b1;
            swapped_next     = ent.swapped;
            minor_down_next  = ent.minor_down;
            major_pos_next   = ent.major_pos;
            major_end_next   = ent.major_end;
            minor_pos_next   = ent.minor_pos;
            major_delta_next = ent.major_delta;
            minor_delta_next = ent.minor_delta;
            err_next         = '0;
            color_next       = ent.color;
        end else if (emit) begin
            if (minor_move) begin
                err_next       = err_acc - $signed({2'b00, major_delta_reg});
                minor_pos_next = minor_down_reg ? minor_pos_reg - CB'(1)
                                                : minor_pos_reg + CB'(1);
            end else begin
                err_next = err_acc;
            end
            if (is_last) begin
                active_next = 1'b0;
            end else begin
                major_pos_next = major_pos_reg + CB'(1);
            end
        end
    end

    // Next output register contents
    always_comb begin
        out_x_next     = out_x_reg;
        out_y_next     = out_y_reg;
        out_color_next = out_color_reg;
        out_last_next  = out_last_reg;
        out_valid_next = out_valid_reg && !m_ready;
        if (emit) begin
            out_valid_next = 1'b1;
            out_x_next     = swapped_reg ? minor_pos_reg : major_pos_reg;
            out_y_next     = swapped_reg ? major_pos_reg : minor_pos_reg;
            out_color_next = color_reg;
            out_last_next  = is_last;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            active_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            active_reg    <= active_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Datapath registers, no reset needed
    always_ff @(posedge aclk) begin
        swapped_reg     <= swapped_next;
        minor_down_reg  <= minor_down_next;
        major_pos_reg   <= major_pos_next;
        major_end_reg   <= major_end_next;
        minor_pos_reg   <= minor_pos_next;
        major_delta_reg <= major_delta_next;
        minor_delta_reg <= minor_delta_next;
        err_reg         <= err_next;
        color_reg       <= color_next;
        out_x_reg       <= out_x_next;
        out_y_reg       <= out_y_next;
        out_color_reg   <= out_color_next;
        out_last_reg    <= out_last_next;
    end

    assign m_valid      = out_valid_reg;
    assign m_pixel_x    = out_x_reg;
    assign m_pixel_y    = out_y_reg;
    assign m_color_out  = out_color_reg;
    assign m_last_pixel = out_last_reg;

    assign status.line_active = active_reg;
    assign status.emit_last   = emit && is_last;

endmodule

`default_nettype wire
